### rtl/aavr_pkg.sv
// Shared types, fixed-point formats and elaboration-time constant tables for the rotator.
package aavr_pkg;

    // Field and internal number formats
    localparam int COORD_W       = 32;
    localparam int FRAC          = 16;
    localparam int UNIT_FRAC     = 28;
    localparam int ANG_FRAC      = 46;
    localparam int GAIN_FRAC     = 30;
    localparam int CORDIC_STAGES = 24;
    localparam int ROOT_W        = 32;
    localparam int UNIT_W        = 30;
    localparam int LW            = 36;
    localparam int ZW            = 50;
    localparam int XW            = 34;
    localparam int RED_STEPS     = 14;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic        [ROOT_W-1:0]  root_t;
    typedef logic signed [UNIT_W-1:0]  unit_t;
    typedef logic signed [LW-1:0]      long_t;
    typedef logic signed [ZW-1:0]      angle_t;
    typedef logic signed [XW-1:0]      gain_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec3_t;

    typedef struct packed {
        unit_t z;
        unit_t y;
        unit_t x;
    } unit3_t;

    // Sideband carried through the square-root pipeline
    typedef struct packed {
        vec3_t vec;
        vec3_t axis;
    } sq_side_t;

    // Sideband carried through the divider
    typedef struct packed {
        logic  zero;
        vec3_t vec;
    } div_side_t;

    // Sideband carried through the sine/cosine pipeline
    typedef struct packed {
        logic   zero;
        vec3_t  vec;
        unit3_t unit;
    } trig_side_t;

    localparam logic signed [63:0] HALF_UNIT = 64'sd1 <<< (UNIT_FRAC - 1);
    localparam logic [63:0] HALF_ANG = 64'd1 << (62 - ANG_FRAC - 1);

    // Magnitude of a signed coordinate as an unsigned value
    function automatic logic [COORD_W-1:0] mag(input coord_t a);
        return a[COORD_W-1] ? COORD_W'(-a) : COORD_W'(a);
    endfunction

    // Round half up and rescale a unit-scaled product
    function automatic long_t rnd_unit(input logic signed [63:0] a);
        logic signed [63:0] t;
        t = (a + HALF_UNIT) >>> UNIT_FRAC;
        return t[LW-1:0];
    endfunction

    // Long division by shift and subtract, for elaboration-time tables only
    function automatic logic [63:0] cdiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(1/d) in Q62 by its Taylor series
    function automatic logic signed [63:0] atan_inv(input logic [63:0] d);
        logic [63:0] p;
        logic [63:0] t;
        logic signed [63:0] sum;
        p = cdiv(64'd1 << 62, d);
        sum = '0;
        for (int k = 0; k < 40; k++) begin
            t = cdiv(p, 64'(2 * k + 1));
            if (k[0]) begin
                sum = sum - $signed(t);
            end else begin
                sum = sum + $signed(t);
            end
            p = cdiv(cdiv(p, d), d);
        end
        return sum;
    endfunction

    // pi/4 in Q62 by Machin's formula
    function automatic logic [63:0] quarter_pi();
        return 64'(64'sd4 * atan_inv(64'd5) - atan_inv(64'd239));
    endfunction

    function automatic logic [63:0] pi_q46();
        return ((quarter_pi() << 2) + HALF_ANG) >> (62 - ANG_FRAC);
    endfunction

    // Arctangent of 2^-i in Q46
    function automatic angle_t atan_entry(input int i);
        logic [63:0] a;
        a = (i == 0) ? quarter_pi() : 64'(atan_inv(64'd1 << i));
        return angle_t'((a + HALF_ANG) >> (62 - ANG_FRAC));
    endfunction

    function automatic logic [63:0] isqrt64(input logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        logic [63:0] rem;
        res = '0;
        rem = n;
        bitv = 64'd1 << 62;
        for (int j = 0; j < 32; j++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // CORDIC inverse gain in Q30
    function automatic gain_t inv_gain();
        logic [63:0] g2;
        logic [63:0] root;
        g2 = 64'd1 << 60;
        for (int i = 0; i < CORDIC_STAGES; i++) begin
            if (2 * i < 64) begin
                g2 = g2 + (g2 >> (2 * i));
            end
        end
        root = isqrt64(g2);
        return gain_t'(cdiv((64'd1 << 60) + (root >> 1), root));
    endfunction

    localparam logic [63:0] PI_Q46     = pi_q46();
    localparam logic [63:0] TWO_PI_Q46 = PI_Q46 << 1;
    localparam angle_t      PI_A       = angle_t'(PI_Q46);
    localparam angle_t      TWO_PI_A   = angle_t'(TWO_PI_Q46);
    localparam angle_t      HALF_PI_A  = angle_t'(PI_Q46 >> 1);
    localparam gain_t       INV_GAIN   = inv_gain();

endpackage

### rtl/aavr_isqrt.sv
// Norm of the rotation vector: squares, sum and a bit-per-stage rounded square root.
module aavr_isqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  aavr_pkg::coord_t       axis_x,
    input  aavr_pkg::coord_t       axis_y,
    input  aavr_pkg::coord_t       axis_z,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output aavr_pkg::root_t        root,
    output logic [SIDE_W-1:0]      out_side
);
    import aavr_pkg::*;

    localparam int STEPS = ROOT_W;
    localparam int TOTAL = STEPS + 3;

    logic [TOTAL-1:0]  vld_reg;
    logic [SIDE_W-1:0] side_reg [TOTAL];
    logic [63:0]       sq_reg [3];
    logic [63:0]       rem_reg [STEPS+1];
    logic [63:0]       res_reg [STEPS+1];
    root_t             root_reg;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
        end
    end

    // Carry the sideband alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int t = 1; t < TOTAL; t++)
            begin
                side_reg[t] <= side_reg[t-1];
            end
        end
    end

    // Square the component magnitudes, then sum them
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0]  <= 64'(mag(axis_x)) * 64'(mag(axis_x));
            sq_reg[1]  <= 64'(mag(axis_y)) * 64'(mag(axis_y));
            sq_reg[2]  <= 64'(mag(axis_z)) * 64'(mag(axis_z));
            rem_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            res_reg[0] <= '0;
        end
    end

    // One root bit a stage
    for (genvar j = 1; j <= STEPS; j++)
    begin : g_root
        localparam logic [63:0] BITV = 64'd1 << (2 * STEPS - 2 * j);
        logic [63:0] trial;
        assign trial = res_reg[j-1] + BITV;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rem_reg[j-1] >= trial)
                begin
                    rem_reg[j] <= rem_reg[j-1] - trial;
                    res_reg[j] <= (res_reg[j-1] >> 1) + BITV;
                end
                else
                begin
                    rem_reg[j] <= rem_reg[j-1];
                    res_reg[j] <= res_reg[j-1] >> 1;
                end
            end
        end
    end

    // Round to nearest
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= res_reg[STEPS][ROOT_W-1:0]
                      + ROOT_W'(rem_reg[STEPS] > res_reg[STEPS]);
        end
    end

    assign out_valid = vld_reg[TOTAL-1];
    assign root      = root_reg;
    assign out_side  = side_reg[TOTAL-1];

endmodule

### rtl/aavr_udiv.sv
// Unit axis: three restoring dividers, one quotient bit per stage, round and clamp.
module aavr_udiv #(
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  aavr_pkg::root_t        root_in,
    input  aavr_pkg::coord_t       axis_x,
    input  aavr_pkg::coord_t       axis_y,
    input  aavr_pkg::coord_t       axis_z,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output aavr_pkg::unit3_t       unit,
    output aavr_pkg::root_t        root_out,
    output logic [SIDE_W-1:0]      out_side
);
    import aavr_pkg::*;

    localparam int STEPS = UNIT_W;
    localparam int NUM_W = COORD_W + UNIT_FRAC;
    localparam int DEN_W = ROOT_W + STEPS;
    localparam int TOTAL = STEPS + 2;
    localparam logic [STEPS-1:0] Q_ONE = STEPS'(1) << UNIT_FRAC;

    logic [TOTAL-1:0]  vld_reg;
    logic [SIDE_W-1:0] side_reg [TOTAL];
    logic [NUM_W-1:0]  rem_reg [3][STEPS+1];
    logic [STEPS-1:0]  quo_reg [3][STEPS+1];
    root_t             den_reg [STEPS+1];
    logic [2:0]        neg_reg [STEPS+1];
    unit_t             unit_reg [3];
    root_t             root_reg;
    coord_t            a_in [3];

    assign a_in[0] = axis_x;
    assign a_in[1] = axis_y;
    assign a_in[2] = axis_z;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
        end
    end

    // Carry the sideband alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int t = 1; t < TOTAL; t++)
            begin
                side_reg[t] <= side_reg[t-1];
            end
        end
    end

    // Form the rounded numerators
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= root_in;
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[l][0] <= {mag(a_in[l]), UNIT_FRAC'(0)} + NUM_W'(root_in >> 1);
                quo_reg[l][0] <= '0;
                neg_reg[0][l] <= a_in[l][COORD_W-1];
            end
        end
    end

    // One quotient bit a stage in each lane
    for (genvar j = 1; j <= STEPS; j++)
    begin : g_div
        localparam int K = STEPS - j;
        logic [DEN_W-1:0] shifted;
        assign shifted = DEN_W'(den_reg[j-1]) << K;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                den_reg[j] <= den_reg[j-1];
                neg_reg[j] <= neg_reg[j-1];
                for (int l = 0; l < 3; l++)
                begin
                    if (DEN_W'(rem_reg[l][j-1]) >= shifted)
                    begin
                        rem_reg[l][j] <= rem_reg[l][j-1] - shifted[NUM_W-1:0];
                        quo_reg[l][j] <= quo_reg[l][j-1] | (STEPS'(1) << K);
                    end
                    else
                    begin
                        rem_reg[l][j] <= rem_reg[l][j-1];
                        quo_reg[l][j] <= quo_reg[l][j-1];
                    end
                end
            end
        end
    end

    // Clamp to one and restore the sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            root_reg <= den_reg[STEPS];
            for (int l = 0; l < 3; l++)
            begin
                if (quo_reg[l][STEPS] > Q_ONE)
                begin
                    unit_reg[l] <= neg_reg[STEPS][l] ? -unit_t'(Q_ONE) : unit_t'(Q_ONE);
                end
                else
                begin
                    unit_reg[l] <= neg_reg[STEPS][l] ? -unit_t'(quo_reg[l][STEPS])
                                                     : unit_t'(quo_reg[l][STEPS]);
                end
            end
        end
    end

    assign out_valid = vld_reg[TOTAL-1];
    assign unit.x    = unit_reg[0];
    assign unit.y    = unit_reg[1];
    assign unit.z    = unit_reg[2];
    assign root_out  = root_reg;
    assign out_side  = side_reg[TOTAL-1];

endmodule

### rtl/aavr_trig.sv
// Angle reduction modulo 2*pi, quadrant fold and pipelined CORDIC for cos and sin.
module aavr_trig #(
    parameter int SIDE_W = 1
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  aavr_pkg::root_t        root,
    input  logic [SIDE_W-1:0]      in_side,
    output logic                   out_valid,
    output aavr_pkg::unit_t        cos_v,
    output aavr_pkg::unit_t        sin_v,
    output logic [SIDE_W-1:0]      out_side
);
    import aavr_pkg::*;

    localparam int N     = CORDIC_STAGES;
    localparam int TOTAL = RED_STEPS + N + 4;
    localparam int RSH   = GAIN_FRAC - UNIT_FRAC;
    localparam gain_t G_ONE  = gain_t'(64'sd1 <<< UNIT_FRAC);
    localparam gain_t G_HALF = gain_t'(64'sd1 <<< (RSH - 1));

    logic [TOTAL-1:0]  vld_reg;
    logic [SIDE_W-1:0] side_reg [TOTAL];
    logic [63:0]       red_reg [RED_STEPS+1];
    angle_t            th_reg;
    angle_t            z_reg [N+1];
    gain_t             x_reg [N+1];
    gain_t             y_reg [N+1];
    logic              neg_reg [N+1];
    unit_t             cos_reg;
    unit_t             sin_reg;
    gain_t             xr;
    gain_t             yr;
    unit_t             xc;
    unit_t             yc;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[TOTAL-2:0], in_valid};
        end
    end

    // Carry the sideband alongside
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= in_side;
            for (int t = 1; t < TOTAL; t++)
            begin
                side_reg[t] <= side_reg[t-1];
            end
        end
    end

    // Scale the angle to the reduction format
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg[0] <= 64'(root) << (ANG_FRAC - FRAC);
        end
    end

    // Subtract one shifted multiple of 2*pi a stage
    for (genvar j = 1; j <= RED_STEPS; j++)
    begin : g_red
        localparam logic [63:0] STEP_VAL = TWO_PI_Q46 << (RED_STEPS - j);
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                red_reg[j] <= (red_reg[j-1] >= STEP_VAL) ? red_reg[j-1] - STEP_VAL
                                                         : red_reg[j-1];
            end
        end
    end

    // Wrap to [-pi, pi), then fold to [-pi/2, pi/2]
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (angle_t'(red_reg[RED_STEPS]) >= PI_A)
            begin
                th_reg <= angle_t'(red_reg[RED_STEPS]) - TWO_PI_A;
            end
            else
            begin
                th_reg <= angle_t'(red_reg[RED_STEPS]);
            end
            x_reg[0] <= INV_GAIN;
            y_reg[0] <= '0;
            if (th_reg > HALF_PI_A)
            begin
                z_reg[0]   <= th_reg - PI_A;
                neg_reg[0] <= 1'b1;
            end
            else if (th_reg < -HALF_PI_A)
            begin
                z_reg[0]   <= th_reg + PI_A;
                neg_reg[0] <= 1'b1;
            end
            else
            begin
                z_reg[0]   <= th_reg;
                neg_reg[0] <= 1'b0;
            end
        end
    end

    // Rotation-mode CORDIC micro-rotations
    for (genvar i = 0; i < N; i++)
    begin : g_cordic
        localparam angle_t ATAN_I = atan_entry(i);
        gain_t dx;
        gain_t dy;
        assign dx = y_reg[i] >>> i;
        assign dy = x_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                neg_reg[i+1] <= neg_reg[i];
                if (z_reg[i] >= 0)
                begin
                    x_reg[i+1] <= x_reg[i] - dx;
                    y_reg[i+1] <= y_reg[i] + dy;
                    z_reg[i+1] <= z_reg[i] - ATAN_I;
                end
                else
                begin
                    x_reg[i+1] <= x_reg[i] + dx;
                    y_reg[i+1] <= y_reg[i] - dy;
                    z_reg[i+1] <= z_reg[i] + ATAN_I;
                end
            end
        end
    end

    // Round to the unit format and clamp to one
    always_comb
    begin
        xr = (x_reg[N] + G_HALF) >>> RSH;
        yr = (y_reg[N] + G_HALF) >>> RSH;
        xc = (xr > G_ONE) ? unit_t'(G_ONE) : ((xr < -G_ONE) ? unit_t'(-G_ONE) : unit_t'(xr));
        yc = (yr > G_ONE) ? unit_t'(G_ONE) : ((yr < -G_ONE) ? unit_t'(-G_ONE) : unit_t'(yr));
    end

    // Undo the fold
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cos_reg <= neg_reg[N] ? -xc : xc;
            sin_reg <= neg_reg[N] ? -yc : yc;
        end
    end

    assign out_valid = vld_reg[TOTAL-1];
    assign cos_v     = cos_reg;
    assign sin_v     = sin_reg;
    assign out_side  = side_reg[TOTAL-1];

endmodule

### rtl/aavr_rotc.sv
// Rodrigues combine: parallel and perpendicular parts, cross product, output saturation.
module aavr_rotc (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  aavr_pkg::vec3_t        vec,
    input  aavr_pkg::unit3_t       unit,
    input  aavr_pkg::unit_t        cos_v,
    input  aavr_pkg::unit_t        sin_v,
    input  logic                   zero,
    output logic                   out_valid,
    output aavr_pkg::coord_t       out_x,
    output aavr_pkg::coord_t       out_y,
    output aavr_pkg::coord_t       out_z,
    output logic                   no_rotation,
    output logic                   saturated
);
    import aavr_pkg::*;

    localparam int STAGES = 8;
    localparam int OW     = LW + 2;
    localparam logic signed [OW-1:0] O_MAX = (OW'(1) <<< (COORD_W - 1)) - OW'(1);
    localparam logic signed [OW-1:0] O_MIN = -O_MAX - OW'(1);

    logic [STAGES-1:0]  vld_reg;
    coord_t             v_in [3];
    unit_t              e_in [3];
    coord_t             v_reg [7][3];
    unit_t              e_reg [5][3];
    unit_t              c_reg [7];
    unit_t              s_reg [7];
    logic               zero_reg [7];
    logic signed [63:0] pp_reg [3];
    long_t              par_reg;
    logic signed [63:0] qp_reg [3];
    long_t              q_reg [4][3];
    long_t              p_reg [3][3];
    logic signed [63:0] m_reg [6];
    long_t              w_reg [3];
    logic signed [63:0] cp_reg [3];
    logic signed [63:0] sw_reg [3];
    coord_t             o_reg [3];
    logic               norot_reg;
    logic               sat_reg;
    logic signed [OW-1:0] o_sum [3];
    logic               o_hi [3];
    logic               o_lo [3];

    assign v_in[0] = vec.x;
    assign v_in[1] = vec.y;
    assign v_in[2] = vec.z;
    assign e_in[0] = unit.x;
    assign e_in[1] = unit.y;
    assign e_in[2] = unit.z;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
        end
    end

    // Carry operands down the stages
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_reg[0]    <= cos_v;
            s_reg[0]    <= sin_v;
            zero_reg[0] <= zero;
            for (int t = 1; t < 7; t++)
            begin
                c_reg[t]    <= c_reg[t-1];
                s_reg[t]    <= s_reg[t-1];
                zero_reg[t] <= zero_reg[t-1];
                v_reg[t]    <= v_reg[t-1];
            end
            v_reg[0] <= v_in;
            e_reg[0] <= e_in;
            for (int t = 1; t < 5; t++)
            begin
                e_reg[t] <= e_reg[t-1];
            end
            for (int t = 1; t < 4; t++)
            begin
                q_reg[t] <= q_reg[t-1];
            end
            for (int t = 1; t < 3; t++)
            begin
                p_reg[t] <= p_reg[t-1];
            end
        end
    end

    // Dot product terms, then the parallel length
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                pp_reg[l] <= v_in[l] * e_in[l];
            end
            par_reg <= rnd_unit(pp_reg[0] + pp_reg[1] + pp_reg[2]);
        end
    end

    // Parallel part and perpendicular remainder
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                qp_reg[l]   <= par_reg * e_reg[1][l];
                q_reg[0][l] <= rnd_unit(qp_reg[l]);
                p_reg[0][l] <= long_t'(v_reg[2][l]) - rnd_unit(qp_reg[l]);
            end
        end
    end

    // Cross product of the axis with the perpendicular part
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg[0] <= e_reg[3][1] * p_reg[0][2];
            m_reg[1] <= e_reg[3][2] * p_reg[0][1];
            m_reg[2] <= e_reg[3][2] * p_reg[0][0];
            m_reg[3] <= e_reg[3][0] * p_reg[0][2];
            m_reg[4] <= e_reg[3][0] * p_reg[0][1];
            m_reg[5] <= e_reg[3][1] * p_reg[0][0];
            w_reg[0] <= rnd_unit(m_reg[0] - m_reg[1]);
            w_reg[1] <= rnd_unit(m_reg[2] - m_reg[3]);
            w_reg[2] <= rnd_unit(m_reg[4] - m_reg[5]);
        end
    end

    // Scale by cosine and sine
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cp_reg[l] <= c_reg[5] * p_reg[2][l];
                sw_reg[l] <= s_reg[5] * w_reg[l];
            end
        end
    end

    // Sum the three terms and saturate
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            o_sum[l] = OW'(q_reg[3][l]) + OW'(rnd_unit(cp_reg[l])) + OW'(rnd_unit(sw_reg[l]));
            o_hi[l]  = o_sum[l] > O_MAX;
            o_lo[l]  = o_sum[l] < O_MIN;
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[6])
            begin
                o_reg     <= v_reg[6];
                norot_reg <= 1'b1;
                sat_reg   <= 1'b0;
            end
            else
            begin
                for (int l = 0; l < 3; l++)
                begin
                    if (o_hi[l])
                    begin
                        o_reg[l] <= coord_t'(O_MAX);
                    end
                    else if (o_lo[l])
                    begin
                        o_reg[l] <= coord_t'(O_MIN);
                    end
                    else
                    begin
                        o_reg[l] <= coord_t'(o_sum[l]);
                    end
                end
                norot_reg <= 1'b0;
                sat_reg   <= o_hi[0] | o_lo[0] | o_hi[1] | o_lo[1] | o_hi[2] | o_lo[2];
            end
        end
    end

    assign out_valid   = vld_reg[STAGES-1];
    assign out_x       = o_reg[0];
    assign out_y       = o_reg[1];
    assign out_z       = o_reg[2];
    assign no_rotation = norot_reg;
    assign saturated   = sat_reg;

endmodule

### rtl/axis_angle_vector_rotate.sv
// Top level of the axis-angle vector rotator (Rodrigues' formula), streaming in and out.
//
// Input channel s_axis carries one vector and one rotation vector per transfer; the
// rotation vector's length is the angle in radians, its direction the axis. Output
// channel m_axis returns the rotated vector, saturated to Q16.16, with a no-rotation
// flag (zero rotation vector, vector passed unchanged) and a saturation flag in tuser.
// All components are signed Q16.16.
//
// From input transfer to output valid an item passes the squares and the bit-per-stage
// square root, the axis divider, the reduction modulo 2*pi and the 24-stage CORDIC,
// then the final products and the output register. Throughput is one transfer per cycle;
// the whole pipeline moves in lockstep and advances whenever the output register is
// empty or being taken.
//
// Reset clears every valid bit; nothing is in flight afterwards. When the receiver
// holds m_axis_tready low with a result waiting, the pipeline freezes and s_axis_tready
// drops, so items are neither lost nor repeated.
module axis_angle_vector_rotate (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x[31:0], vec_y[63:32], vec_z[95:64], axis_x[127:96], axis_y[159:128],
    // axis_z[191:160]
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]  m_axis_tdata,
    // no_rotation[0], saturated[1]
    output logic [1:0]   m_axis_tuser
);
    import aavr_pkg::*;

    logic       en;
    sq_side_t   sq_in;
    sq_side_t   sq_out;
    logic       sq_valid;
    root_t      sq_root;
    div_side_t  div_in;
    div_side_t  div_out;
    logic       div_valid;
    unit3_t     div_unit;
    root_t      div_root;
    trig_side_t trig_in;
    trig_side_t trig_out;
    logic       trig_valid;
    unit_t      trig_cos;
    unit_t      trig_sin;
    coord_t     res_x;
    coord_t     res_y;
    coord_t     res_z;
    logic       res_norot;
    logic       res_sat;

    // Move the pipeline while the output register is free or drained
    assign en            = ~m_axis_tvalid | m_axis_tready;
    assign s_axis_tready = en;

    // Unpack the input transfer
    assign sq_in.vec.x  = s_axis_tdata[COORD_W-1:0];
    assign sq_in.vec.y  = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign sq_in.vec.z  = s_axis_tdata[3*COORD_W-1:2*COORD_W];
    assign sq_in.axis.x = s_axis_tdata[4*COORD_W-1:3*COORD_W];
    assign sq_in.axis.y = s_axis_tdata[5*COORD_W-1:4*COORD_W];
    assign sq_in.axis.z = s_axis_tdata[6*COORD_W-1:5*COORD_W];

    aavr_isqrt #(
        .SIDE_W ($bits(sq_side_t))
    ) u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .axis_x    (sq_in.axis.x),
        .axis_y    (sq_in.axis.y),
        .axis_z    (sq_in.axis.z),
        .in_side   (sq_in),
        .out_valid (sq_valid),
        .root      (sq_root),
        .out_side  (sq_out)
    );

    // Flag a zero rotation vector
    assign div_in.zero = (sq_root == '0);
    assign div_in.vec  = sq_out.vec;

    aavr_udiv #(
        .SIDE_W ($bits(div_side_t))
    ) u_udiv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .root_in   (sq_root),
        .axis_x    (sq_out.axis.x),
        .axis_y    (sq_out.axis.y),
        .axis_z    (sq_out.axis.z),
        .in_side   (div_in),
        .out_valid (div_valid),
        .unit      (div_unit),
        .root_out  (div_root),
        .out_side  (div_out)
    );

    assign trig_in.zero = div_out.zero;
    assign trig_in.vec  = div_out.vec;
    assign trig_in.unit = div_unit;

    aavr_trig #(
        .SIDE_W ($bits(trig_side_t))
    ) u_trig (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (div_valid),
        .root      (div_root),
        .in_side   (trig_in),
        .out_valid (trig_valid),
        .cos_v     (trig_cos),
        .sin_v     (trig_sin),
        .out_side  (trig_out)
    );

    aavr_rotc u_rotc (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (trig_valid),
        .vec         (trig_out.vec),
        .unit        (trig_out.unit),
        .cos_v       (trig_cos),
        .sin_v       (trig_sin),
        .zero        (trig_out.zero),
        .out_valid   (m_axis_tvalid),
        .out_x       (res_x),
        .out_y       (res_y),
        .out_z       (res_z),
        .no_rotation (res_norot),
        .saturated   (res_sat)
    );

    // Pack the output transfer
    assign m_axis_tdata = {res_z, res_y, res_x};
    assign m_axis_tuser = {res_sat, res_norot};

endmodule

### rtl/aavr_chk.sv
// Port-level checks on the rotator, attached to the top level by bind.
module aavr_chk (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [191:0] s_axis_tdata,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [95:0]  m_axis_tdata,
    input logic [1:0]   m_axis_tuser
);

    // Hold a stalled output transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output transfer changed");

    // Input side is ready exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("input ready does not follow output stall");

    // A passed-through vector is never reported as clipped
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("no_rotation and saturated both set");

    // Nothing is offered when reset lifts
    a_reset: assert property (@(posedge clk)
        $rose(rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    // A saturated result is never flagged as no rotation
    a_norot_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
        else $error("saturated result flagged as no rotation");

endmodule

bind axis_angle_vector_rotate aavr_chk u_aavr_chk (.*);

### dv/rotate_checker.sv
// Checker for the axis-angle rotator: predicts each rotated vector and compares results.
`timescale 1ns / 100ps

module rotate_checker (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [191:0] s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [95:0]  m_axis_tdata,
    input  logic [1:0]   m_axis_tuser,
    output int           fail_count,
    output int           pending
);

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        no_rot;
        logic        sat;
    } rot_result_t;

    localparam int      STAGES    = 24;
    localparam longint  UNIT_ONE  = 64'sd1 <<< 28;
    localparam longint  COORD_MAX = 64'sd2147483647;
    localparam longint  COORD_MIN = -64'sd2147483648;

    rot_result_t expected_rot[$];
    longint      atan_tab[STAGES];
    longint      pi_q46;
    longint      inv_gain_q30;

    // Integer square root with remainder
    function automatic longint unsigned root_floor(input longint unsigned n,
                                                   output longint unsigned rem);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        rem = n;
        return res;
    endfunction

    // atan(1/d) in Q62 by series expansion
    function automatic longint arctan_recip(input longint unsigned d);
        longint unsigned p;
        longint unsigned k;
        longint          acc;
        longint          t;
        p = (64'd1 << 62) / d;
        acc = 0;
        k = 0;
        while (p != 0)
        begin
            t = longint'(p / (2 * k + 1));
            acc = k[0] ? acc - t : acc + t;
            p = p / d / d;
            k++;
        end
        return acc;
    endfunction

    function automatic longint round_unit(input longint a);
        return (a + (64'sd1 <<< 27)) >>> 28;
    endfunction

    function automatic longint clamp_one(input longint a);
        return a > UNIT_ONE ? UNIT_ONE : (a < -UNIT_ONE ? -UNIT_ONE : a);
    endfunction

    // Rotate one vector about its rotation vector
    function automatic rot_result_t rotate_vector(input logic [191:0] d);
        rot_result_t     res;
        longint          v[3];
        longint          a[3];
        longint          e[3];
        longint          q[3];
        longint          p[3];
        longint          w[3];
        longint          par;
        longint          theta;
        longint          cx;
        longint          cy;
        longint          cz;
        longint          dx;
        longint          dy;
        longint          o;
        longint unsigned n2;
        longint unsigned r;
        longint unsigned rem;
        longint unsigned m;
        longint unsigned red;
        logic            flip;
        n2 = 0;
        flip = 1'b0;
        res.sat = 1'b0;
        res.no_rot = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            v[i] = longint'($signed(d[32*i +: 32]));
            a[i] = longint'($signed(d[96 + 32*i +: 32]));
            m = longint'(a[i] < 0 ? -a[i] : a[i]);
            n2 += m * m;
        end
        r = root_floor(n2, rem);
        if (rem > r)
            r++;
        // Zero rotation vector: pass the vector through
        if (r == 0)
        begin
            res.x = d[31:0];
            res.y = d[63:32];
            res.z = d[95:64];
            res.no_rot = 1'b1;
            return res;
        end
        for (int i = 0; i < 3; i++)
        begin
            m = (longint'(a[i] < 0 ? -a[i] : a[i]) << 28) + r / 2;
            e[i] = clamp_one(longint'(m / r));
            if (a[i] < 0)
                e[i] = -e[i];
        end
        par = round_unit(v[0] * e[0] + v[1] * e[1] + v[2] * e[2]);
        for (int i = 0; i < 3; i++)
        begin
            q[i] = round_unit(par * e[i]);
            p[i] = v[i] - q[i];
        end
        w[0] = round_unit(e[1] * p[2] - e[2] * p[1]);
        w[1] = round_unit(e[2] * p[0] - e[0] * p[2]);
        w[2] = round_unit(e[0] * p[1] - e[1] * p[0]);
        // Reduce the angle modulo 2*pi and fold into [-pi/2, pi/2]
        red = (r << 30) % longint'(2 * pi_q46);
        theta = longint'(red);
        if (theta >= pi_q46)
            theta -= 2 * pi_q46;
        if (theta > pi_q46 / 2)
        begin
            theta -= pi_q46;
            flip = 1'b1;
        end
        else if (theta < -(pi_q46 / 2))
        begin
            theta += pi_q46;
            flip = 1'b1;
        end
        cx = inv_gain_q30;
        cy = 0;
        cz = theta;
        for (int i = 0; i < STAGES; i++)
        begin
            dx = cy >>> i;
            dy = cx >>> i;
            if (cz >= 0)
            begin
                cx -= dx;
                cy += dy;
                cz -= atan_tab[i];
            end
            else
            begin
                cx += dx;
                cy -= dy;
                cz += atan_tab[i];
            end
        end
        cx = clamp_one((cx + 2) >>> 2);
        cy = clamp_one((cy + 2) >>> 2);
        if (flip)
        begin
            cx = -cx;
            cy = -cy;
        end
        for (int i = 0; i < 3; i++)
        begin
            o = q[i] + round_unit(cx * p[i]) + round_unit(cy * w[i]);
            if (o > COORD_MAX)
            begin
                o = COORD_MAX;
                res.sat = 1'b1;
            end
            else if (o < COORD_MIN)
            begin
                o = COORD_MIN;
                res.sat = 1'b1;
            end
            case (i)
                0: res.x = o[31:0];
                1: res.y = o[31:0];
                default: res.z = o[31:0];
            endcase
        end
        return res;
    endfunction

    // Build the arctangent table, pi and the inverse gain
    initial
    begin
        longint          quarter;
        longint unsigned g2;
        longint unsigned rt;
        longint unsigned rm;
        quarter = 4 * arctan_recip(5) - arctan_recip(239);
        atan_tab[0] = longint'((longint'(quarter) + (64'sd1 <<< 15)) >>> 16);
        for (int i = 1; i < STAGES; i++)
            atan_tab[i] = (arctan_recip(64'd1 << i) + (64'sd1 <<< 15)) >>> 16;
        pi_q46 = longint'(((longint'(quarter) * 4) + (64'd1 << 15)) >> 16);
        g2 = 64'd1 << 60;
        for (int i = 0; i < STAGES; i++)
            g2 += g2 >> (2 * i);
        rt = root_floor(g2, rm);
        inv_gain_q30 = longint'(((64'd1 << 60) + rt / 2) / rt);
    end

    assign pending = expected_rot.size();

    // Predict on each input transfer, compare on each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        rot_result_t exp_r;
        if (!rst_n)
        begin
            fail_count <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_rot.insert(expected_rot.size(), rotate_vector(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_rot.size() == 0)
                begin
                    $display("%0t: result with nothing expected: data %h user %b",
                             $time, m_axis_tdata, m_axis_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_rot.pop_front();
                    if (m_axis_tdata[31:0] !== exp_r.x || m_axis_tdata[63:32] !== exp_r.y
                        || m_axis_tdata[95:64] !== exp_r.z || m_axis_tuser[0] !== exp_r.no_rot
                        || m_axis_tuser[1] !== exp_r.sat)
                    begin
                        $display("%0t: mismatch x/y/z/norot/sat expected %h %h %h %b %b",
                                 $time, exp_r.x, exp_r.y, exp_r.z, exp_r.no_rot, exp_r.sat);
                        $display("%0t:                           actual %h %h %h %b %b",
                                 $time, m_axis_tdata[31:0], m_axis_tdata[63:32],
                                 m_axis_tdata[95:64], m_axis_tuser[0], m_axis_tuser[1]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

### dv/tb.sv
// Testbench top for the axis-angle rotator: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb;

    localparam int N_RANDOM   = 1830;
    localparam int QUIET_FROM = 1650;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 400;
    localparam int DRAIN      = 140;
    localparam int PI_HALF    = 102944;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    int           fail_count;
    int           pending;
    int           sent;
    logic         hold_req;

    axis_angle_vector_rotate u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    rotate_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial
        clk = 1'b0;
    always
        #2 clk = ~clk;

    function automatic logic [191:0] pack_rot(input int vx, input int vy, input int vz,
                                              input int ax, input int ay, input int az);
        return {az, ay, ax, vz, vy, vx};
    endfunction

    // Random value, mostly within the bound, else a power of two, an extreme or full range
    function automatic int pick_coord(input int bound);
        case ($urandom_range(0, 5))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            2:       return $urandom_range(0, 1) ? (32'sd1 <<< $urandom_range(0, 30))
                                                 : -(32'sd1 <<< $urandom_range(0, 31));
            default: return int'($urandom_range(0, 2 * bound)) - bound;
        endcase
    endfunction

    function automatic logic [191:0] random_item();
        int b;
        b = $urandom_range(0, 3) == 0 ? 32'h7fffffff : (1 << $urandom_range(4, 24));
        case ($urandom_range(0, 9))
            0:       return {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            1:       return pack_rot(pick_coord(b), pick_coord(b), pick_coord(b), 0, 0, 0);
            2:       return pack_rot(pick_coord(b), pick_coord(b), pick_coord(b),
                                     0, 0, pick_coord(1 << $urandom_range(0, 22)));
            default: return pack_rot(pick_coord(b), pick_coord(b), pick_coord(b),
                                     pick_coord(1 << 20), pick_coord(1 << 20),
                                     pick_coord(1 << 20));
        endcase
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_item(input logic [191:0] d);
        int gap;
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = d;
        @(posedge clk iff s_axis_tready);
        sent++;
        @(negedge clk);
        if (sent < QUIET_FROM && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 12);
            s_axis_tvalid = 1'b0;
            repeat (gap)
                @(negedge clk);
        end
    endtask

    // Receiver: random stalls, one long hold-off, none near the end
    initial
    begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_axis_tready = 1'b0;
                repeat (HOLD_LEN)
                    @(negedge clk);
            end
            else if (sent >= QUIET_FROM || $urandom_range(0, 1) == 0)
            begin
                m_axis_tready = 1'b1;
                repeat ($urandom_range(1, 12) - 1)
                    @(negedge clk);
            end
            else
            begin
                m_axis_tready = 1'b0;
                repeat ($urandom_range(1, 12) - 1)
                    @(negedge clk);
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        sent          = 0;
        hold_req      = 1'b0;
        repeat (5)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Zero rotation vector with extreme vectors
        send_item(pack_rot(32'h7fffffff, 32'h80000000, 0, 0, 0, 0));
        send_item(pack_rot(32'h80000000, 32'h7fffffff, -1, 0, 0, 0));
        // Smallest rotation vectors
        send_item(pack_rot(65536, 65536, 65536, 1, 0, 0));
        send_item(pack_rot(-65536, 12345, 7, 0, 0, -1));
        // Quarter turns about each axis, half and full turns about z, three-quarter turn about x
        send_item(pack_rot(65536, 0, 0, 0, 0, PI_HALF));
        send_item(pack_rot(0, 65536, 0, PI_HALF, 0, 0));
        send_item(pack_rot(0, 0, 65536, 0, -PI_HALF, 0));
        send_item(pack_rot(65536, 131072, 0, 0, 0, 2 * PI_HALF));
        send_item(pack_rot(65536, 131072, 0, 0, 0, 4 * PI_HALF));
        send_item(pack_rot(65536, 131072, -196608, 3 * PI_HALF, 0, 0));
        // Extreme rotation vectors, large angle reduction
        send_item(pack_rot(65536, -65536, 65536, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        send_item(pack_rot(65536, 65536, 65536, 32'h80000000, 32'h80000000, 32'h80000000));
        send_item(pack_rot(100, 200, 300, 32'h80000000, 0, 0));
        send_item(pack_rot(100, 200, 300, 0, 32'h7fffffff, 1));
        // Axis component rounds to one
        send_item(pack_rot(5000, -7000, 9000, 32'h7fffffff, 1, 1));
        send_item(pack_rot(5000, -7000, 9000, 3, 0, 0));
        // Saturating results, then all ones in every field
        send_item(pack_rot(32'h7fffffff, 32'h7fffffff, 0, 0, 0, PI_HALF / 2));
        send_item(pack_rot(32'h80000000, 32'h80000000, 32'h80000000, 65536, 65536, 0));
        send_item(pack_rot(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 40000, -30000, 20000));
        send_item(pack_rot(32'hffffffff, 32'hffffffff, 32'hffffffff,
                           32'hffffffff, 32'hffffffff, 32'hffffffff));

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i == HOLD_AT)
                hold_req = 1'b1;
            send_item(random_item());
        end
        s_axis_tvalid = 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN)
            @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
